/* sv/lmsc_pkg.sv */
`default_nettype none
package lmsc_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_PUT  = 2'd2,
        FUNC_TOP  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         target_stack;
        logic [3:0]         source_stack;
        logic signed [31:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_value;
    } t_out_word;

    localparam int unsigned CFG_BITS   = 5;
    localparam int unsigned CFG_RESET  = 16;

    // The word fields are sized for these; they do not vary.
    localparam int unsigned NUM_STACKS = 16;
    localparam int unsigned VALUE_BITS = 32;

endpackage
`default_nettype wire

/* sv/lmsc_ram.sv */
`default_nettype none
module lmsc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/linked_multi_stack_with_concat.sv */
// A request is taken only in S_IDLE; its node is read and written back in S_READ,
// and the result word is registered and shown in S_OUT, held there until the
// receiver takes it, so no new request is taken before the last result is taken.
// Push reads the free head or takes an unused node, pop and top read the node at
// the target stack head; put reads the source's tail node before relinking it.
// Reset (synchronous, active low) empties all stacks and the free list and
// restores active_stacks to 16; no clearing pass is needed.
`default_nettype none
module linked_multi_stack_with_concat
    import lmsc_pkg::*;
#(
    parameter int unsigned POOL_NODES = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire t_in_word        i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output t_out_word            o_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_BITS-1:0]   i_cfg_data
);
    localparam int unsigned AW = $clog2(POOL_NODES);
    localparam int unsigned SW = $clog2(NUM_STACKS);
    localparam int unsigned MW = VALUE_BITS + AW + 1;

    t_state r_state, n_state;
    t_in_word r_req;
    logic [CFG_BITS-1:0] r_active;
    logic [AW-1:0] r_head [NUM_STACKS];
    logic [AW-1:0] r_tail [NUM_STACKS];
    logic [NUM_STACKS-1:0] r_ne;
    logic [AW-1:0] r_free_head;
    logic r_free_ne;
    logic [AW:0] r_unused;
    t_out_word r_out, n_out;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata, mem_rdata;

    lmsc_ram #(.WIDTH(MW), .DEPTH(POOL_NODES)) u_nodes (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    // Memory word layout: {value, link, link_valid}.
    logic [VALUE_BITS-1:0] rd_val;
    logic [AW-1:0] rd_link;
    logic rd_lv;
    assign rd_val  = mem_rdata[MW-1 -: VALUE_BITS];
    assign rd_link = mem_rdata[AW:1];
    assign rd_lv   = mem_rdata[0];

    logic [SW-1:0] t_idx, s_idx;
    logic t_ok, s_ok;
    assign t_idx = r_req.target_stack[SW-1:0];
    assign s_idx = r_req.source_stack[SW-1:0];
    always_comb begin
        t_ok = (32'(r_req.target_stack) < 32'(r_active))
            && (32'(r_req.target_stack) < NUM_STACKS);
        s_ok = (32'(r_req.source_stack) < 32'(r_active))
            && (32'(r_req.source_stack) < NUM_STACKS);
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;
    assign o_valid     = (r_state == S_OUT);
    assign o_data      = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Read address is chosen in S_IDLE from the incoming word, then used in S_READ.
    always_comb begin
        mem_raddr = r_free_head;
        if (r_state == S_IDLE) begin
            if (t_func'(i_data.func) == FUNC_PUSH) begin
                mem_raddr = r_free_head;
            end else if (t_func'(i_data.func) == FUNC_PUT) begin
                if (32'(i_data.source_stack) < NUM_STACKS) begin
                    mem_raddr = r_tail[i_data.source_stack[SW-1:0]];
                end
            end else if (32'(i_data.target_stack) < NUM_STACKS) begin
                mem_raddr = r_head[i_data.target_stack[SW-1:0]];
            end
        end
    end

    // Node writes, all in S_READ.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_free_head;
        mem_wdata = '0;
        if (r_state == S_READ && t_ok) begin
            case (t_func'(r_req.func))
                FUNC_PUSH: begin
                    if (r_free_ne || r_unused < (AW+1)'(POOL_NODES)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_ne ? r_free_head : r_unused[AW-1:0];
                        mem_wdata = {r_req.push_value[VALUE_BITS-1:0], r_head[t_idx],
                                     r_ne[t_idx]};
                    end
                end
                FUNC_POP: begin
                    if (r_ne[t_idx]) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_head[t_idx];
                        mem_wdata = {rd_val, r_free_head, r_free_ne};
                    end
                end
                FUNC_PUT: begin
                    if (s_ok && s_idx != t_idx && r_ne[s_idx]) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_tail[s_idx];
                        mem_wdata = {rd_val, r_head[t_idx], r_ne[t_idx]};
                    end
                end
                default: ;
            endcase
        end
    end

    // Result word of the request in S_READ.
    always_comb begin
        n_out = '{status: ST_OK, top_value: '0};
        if (!t_ok) begin
            n_out.status = ST_BAD;
        end else begin
            case (t_func'(r_req.func))
                FUNC_PUSH: begin
                    if (!(r_free_ne || r_unused < (AW+1)'(POOL_NODES))) begin
                        n_out.status = ST_FULL;
                    end
                end
                FUNC_POP: begin
                    if (!r_ne[t_idx]) begin
                        n_out.status = ST_EMPTY;
                    end
                end
                FUNC_PUT: begin
                    if (!s_ok || s_idx == t_idx) begin
                        n_out.status = ST_BAD;
                    end
                end
                default: begin
                    if (r_ne[t_idx]) begin
                        n_out.top_value = 32'(signed'(rd_val));
                    end else begin
                        n_out.status = ST_EMPTY;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= CFG_BITS'(CFG_RESET);
            r_ne        <= '0;
            r_free_head <= '0;
            r_free_ne   <= 1'b0;
            r_unused    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (r_state == S_IDLE && i_valid) begin
                r_req <= i_data;
            end
            if (r_state == S_READ) begin
                r_out <= n_out;
                if (t_ok) begin
                    case (t_func'(r_req.func))
                        FUNC_PUSH: begin
                            if (r_free_ne) begin
                                r_free_head <= rd_link;
                                r_free_ne   <= rd_lv;
                            end else if (r_unused < (AW+1)'(POOL_NODES)) begin
                                r_unused <= r_unused + 1'b1;
                            end
                            if (r_free_ne || r_unused < (AW+1)'(POOL_NODES)) begin
                                if (!r_ne[t_idx]) begin
                                    r_tail[t_idx] <= mem_waddr;
                                end
                                r_head[t_idx] <= mem_waddr;
                                r_ne[t_idx]   <= 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            if (r_ne[t_idx]) begin
                                r_head[t_idx] <= rd_link;
                                r_ne[t_idx]   <= rd_lv;
                                r_free_head   <= r_head[t_idx];
                                r_free_ne     <= 1'b1;
                            end
                        end
                        FUNC_PUT: begin
                            if (s_ok && s_idx != t_idx && r_ne[s_idx]) begin
                                if (!r_ne[t_idx]) begin
                                    r_tail[t_idx] <= r_tail[s_idx];
                                end
                                r_head[t_idx] <= r_head[s_idx];
                                r_ne[t_idx]   <= 1'b1;
                                r_ne[s_idx]   <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/lmsc_checker.sv */
`default_nettype none
module lmsc_checker
    import lmsc_pkg::*;
(
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_valid,
    input wire            o_ready,
    input wire            o_valid,
    input wire            i_ready,
    input wire t_out_word o_data
);
    // An accepted word yields a result once the block has passed S_READ into S_OUT.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> ##2 o_valid) else $error("result missing");
    // No new word is taken while a result is shown.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready during result");
    // A status other than ok never comes with a nonzero top value.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_OK) |-> o_data.top_value == '0)
        else $error("nonzero value on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");
endmodule

bind linked_multi_stack_with_concat lmsc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
`default_nettype wire
